// ----- rtl/run_and_timed_job_scheduler_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the job scheduler
// Concurrent checks, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef RUN_AND_TIMED_JOB_SCHEDULER_TOP_DEFINES_SVH
`define RUN_AND_TIMED_JOB_SCHEDULER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RTJS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RTJS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTJS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define RTJS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/rtjs_pkg.sv -----
// ----------------------------------------------------------------------------
// rtjs_pkg
// Types and constants shared by the job scheduler modules
// ----------------------------------------------------------------------------
package rtjs_pkg;

  localparam int JOB_SLOTS    = 16;
  localparam int SLOT_BITS    = $clog2(JOB_SLOTS);
  localparam int PTR_BITS     = SLOT_BITS + 1;
  localparam int TIME_BITS    = 32;
  localparam int HANDLER_BITS = 8;

  typedef logic [SLOT_BITS-1:0]    slot_idx_t;
  typedef logic [PTR_BITS-1:0]     ptr_t;
  typedef logic [TIME_BITS-1:0]    tick_t;
  typedef logic [HANDLER_BITS-1:0] handler_t;

  localparam ptr_t NIL_SLOT = ptr_t'(JOB_SLOTS);

  typedef enum logic [1:0] {
    REQ_RUN    = 2'd0,
    REQ_TIMED  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_POLL   = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    Q_NONE  = 2'd0,
    Q_RUN   = 2'd1,
    Q_TIMED = 2'd2
  } queue_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POLL,
    S_SEEK,
    S_DETACH,
    S_PLACE,
    S_LINK_RUN,
    S_TWALK,
    S_TLINK
  } state_t;

  typedef struct packed {
    req_code_t                    req_type;
    slot_idx_t                    job_slot;
    handler_t                     handler_id;
    logic signed [TIME_BITS-1:0]  due_time;
    logic signed [TIME_BITS-1:0]  now_time;
  } req_t;

  typedef struct packed {
    slot_idx_t run_slot;
    handler_t  run_handler;
    logic      from_timed;
  } result_t;

  typedef struct packed {
    logic      next_we;
    slot_idx_t next_addr;
    ptr_t      next_data;
    logic      handler_we;
    logic      deadline_we;
    slot_idx_t slot_addr;
    handler_t  handler;
    tick_t     deadline;
    logic      queue_we;
    slot_idx_t queue_addr;
    queue_t    queue;
  } store_wr_t;

endpackage

// ----- rtl/rtjs_slot_store.sv -----
// ----------------------------------------------------------------------------
// rtjs_slot_store
// Per-slot link, deadline, handler and queue tag; one read port for link, deadline and handler, one for the queue tag
// ----------------------------------------------------------------------------
module rtjs_slot_store (
  input  logic                clk,
  input  logic                rst,
  input  rtjs_pkg::store_wr_t wr,
  input  rtjs_pkg::slot_idx_t rd_addr,
  input  rtjs_pkg::slot_idx_t q_addr,
  output rtjs_pkg::ptr_t      rd_next,
  output rtjs_pkg::tick_t     rd_deadline,
  output rtjs_pkg::handler_t  rd_handler,
  output rtjs_pkg::queue_t    rd_queue
);
  import rtjs_pkg::*;

  ptr_t     next_mem     [JOB_SLOTS];
  tick_t    deadline_mem [JOB_SLOTS];
  handler_t handler_mem  [JOB_SLOTS];
  queue_t   queue_mem    [JOB_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.deadline_we) begin
      deadline_mem[wr.slot_addr] <= wr.deadline;
    end
    if (wr.handler_we) begin
      handler_mem[wr.slot_addr] <= wr.handler;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOB_SLOTS; i++) begin
        queue_mem[i] <= Q_NONE;
      end
    end else if (wr.queue_we) begin
      queue_mem[wr.queue_addr] <= wr.queue;
    end
  end

  assign rd_next     = next_mem[rd_addr];
  assign rd_deadline = deadline_mem[rd_addr];
  assign rd_handler  = handler_mem[rd_addr];
  assign rd_queue    = queue_mem[q_addr];

endmodule

// ----- rtl/run_and_timed_job_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// run_and_timed_job_scheduler_top
// Run queue and deadline-ordered timed queue over a fixed set of job slots
// Poll: busy while in S_POLL; the result strobe is registered from S_POLL when a job is dispatched.
// Set and remove: S_SEEK, S_DETACH if the slot is queued, S_PLACE; then S_LINK_RUN or S_TWALK and S_TLINK.
// Set and remove walk the linked list one node per cycle through the single
// slot-store link read port; a timed set also uses the shared deadline subtractor.
// Reset empties both queues; the result strobe goes low.
// ----------------------------------------------------------------------------
`include "run_and_timed_job_scheduler_top_defines.svh"

module run_and_timed_job_scheduler_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rtjs_pkg::req_t    req,
  output logic              done,
  output rtjs_pkg::result_t result
);
  import rtjs_pkg::*;

  state_t    state, state_next;
  req_t      cur_req;
  queue_t    qsel, qsel_next;
  ptr_t      cur, cur_next;
  ptr_t      prev, prev_next;
  ptr_t      run_head, run_head_next;
  ptr_t      run_tail, run_tail_next;
  ptr_t      timed_head, timed_head_next;
  logic      done_next;
  result_t   result_next;

  store_wr_t wr;
  slot_idx_t rd_addr;
  ptr_t      rd_next;
  tick_t     rd_deadline;
  handler_t  rd_handler;
  queue_t    rd_queue;

  slot_idx_t s;
  ptr_t      s_ptr;
  logic      poll_from_run;
  ptr_t      poll_ptr;
  tick_t     sub_b;
  tick_t     diff;
  logic      reached;

  assign busy          = (state != S_IDLE);
  assign s             = cur_req.job_slot;
  assign s_ptr         = {1'b0, s};
  assign poll_from_run = (run_head != NIL_SLOT);
  assign poll_ptr      = poll_from_run ? run_head : timed_head;
  assign rd_addr       = (state == S_POLL) ? poll_ptr[SLOT_BITS-1:0] : cur[SLOT_BITS-1:0];

  // shared wrapping compare
  assign sub_b   = (state == S_POLL) ? tick_t'(cur_req.now_time) : tick_t'(cur_req.due_time);
  assign diff    = rd_deadline - sub_b;
  assign reached = (diff == '0) || diff[TIME_BITS-1];

  rtjs_slot_store u_store (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .rd_addr     (rd_addr),
    .q_addr      (s),
    .rd_next     (rd_next),
    .rd_deadline (rd_deadline),
    .rd_handler  (rd_handler),
    .rd_queue    (rd_queue)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (req.req_type == REQ_POLL) ? S_POLL : S_SEEK;
        end
      end
      S_POLL: begin
        state_next = S_IDLE;
      end
      S_SEEK: begin
        state_next = (rd_queue == Q_NONE) ? S_PLACE : S_DETACH;
      end
      S_DETACH: begin
        if (cur == NIL_SLOT || cur == s_ptr) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        unique case (cur_req.req_type)
          REQ_RUN: begin
            state_next = (run_tail == NIL_SLOT || run_head == NIL_SLOT) ? S_IDLE : S_LINK_RUN;
          end
          REQ_TIMED: state_next = S_TWALK;
          REQ_REMOVE, REQ_POLL: state_next = S_IDLE;
        endcase
      end
      S_LINK_RUN: begin
        state_next = S_IDLE;
      end
      S_TWALK: begin
        if (cur == NIL_SLOT || !reached) begin
          state_next = S_TLINK;
        end
      end
      S_TLINK: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    wr              = '0;
    qsel_next       = qsel;
    cur_next        = cur;
    prev_next       = prev;
    run_head_next   = run_head;
    run_tail_next   = run_tail;
    timed_head_next = timed_head;
    done_next       = 1'b0;
    result_next     = result;
    wr.slot_addr    = s;
    wr.handler      = cur_req.handler_id;
    wr.deadline     = tick_t'(cur_req.due_time);
    wr.queue_addr   = s;
    unique case (state)
      S_IDLE: begin
      end
      S_POLL: begin
        if (poll_from_run || (timed_head != NIL_SLOT && reached)) begin
          if (poll_from_run) begin
            run_head_next = rd_next;
            if (rd_next == NIL_SLOT) begin
              run_tail_next = NIL_SLOT;
            end
          end else begin
            timed_head_next = rd_next;
          end
          wr.queue_we            = 1'b1;
          wr.queue_addr          = poll_ptr[SLOT_BITS-1:0];
          wr.queue               = Q_NONE;
          done_next              = 1'b1;
          result_next.run_slot    = poll_ptr[SLOT_BITS-1:0];
          result_next.run_handler = rd_handler;
          result_next.from_timed  = !poll_from_run;
        end
      end
      S_SEEK: begin
        qsel_next = rd_queue;
        prev_next = NIL_SLOT;
        cur_next  = (rd_queue == Q_RUN) ? run_head : timed_head;
      end
      S_DETACH: begin
        if (cur == s_ptr) begin
          if (prev == NIL_SLOT) begin
            if (qsel == Q_RUN) begin
              run_head_next = rd_next;
            end else begin
              timed_head_next = rd_next;
            end
          end else begin
            wr.next_we   = 1'b1;
            wr.next_addr = prev[SLOT_BITS-1:0];
            wr.next_data = rd_next;
          end
          if (qsel == Q_RUN && run_tail == s_ptr) begin
            run_tail_next = prev;
          end
          wr.queue_we = 1'b1;
          wr.queue    = Q_NONE;
        end else if (cur == NIL_SLOT) begin
          wr.queue_we = 1'b1;
          wr.queue    = Q_NONE;
        end else begin
          prev_next = cur;
          cur_next  = rd_next;
        end
      end
      S_PLACE: begin
        unique case (cur_req.req_type)
          REQ_RUN: begin
            wr.handler_we = 1'b1;
            wr.next_we    = 1'b1;
            wr.next_addr  = s;
            wr.next_data  = NIL_SLOT;
            wr.queue_we   = 1'b1;
            wr.queue      = Q_RUN;
            if (run_tail == NIL_SLOT || run_head == NIL_SLOT) begin
              run_head_next = s_ptr;
              run_tail_next = s_ptr;
            end
          end
          REQ_TIMED: begin
            wr.handler_we  = 1'b1;
            wr.deadline_we = 1'b1;
            prev_next      = NIL_SLOT;
            cur_next       = timed_head;
          end
          REQ_REMOVE, REQ_POLL: begin
          end
        endcase
      end
      S_LINK_RUN: begin
        wr.next_we    = 1'b1;
        wr.next_addr  = run_tail[SLOT_BITS-1:0];
        wr.next_data  = s_ptr;
        run_tail_next = s_ptr;
      end
      S_TWALK: begin
        if (cur == NIL_SLOT || !reached) begin
          wr.next_we   = 1'b1;
          wr.next_addr = s;
          wr.next_data = cur;
        end else begin
          prev_next = cur;
          cur_next  = rd_next;
        end
      end
      S_TLINK: begin
        if (prev == NIL_SLOT) begin
          timed_head_next = s_ptr;
        end else begin
          wr.next_we   = 1'b1;
          wr.next_addr = prev[SLOT_BITS-1:0];
          wr.next_data = s_ptr;
        end
        wr.queue_we = 1'b1;
        wr.queue    = Q_TIMED;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run_head   <= NIL_SLOT;
      run_tail   <= NIL_SLOT;
      timed_head <= NIL_SLOT;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      run_head   <= run_head_next;
      run_tail   <= run_tail_next;
      timed_head <= timed_head_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur_req <= req;
    end
    qsel   <= qsel_next;
    cur    <= cur_next;
    prev   <= prev_next;
    result <= result_next;
  end

  `RTJS_ASSERT_IMPLIES(a_done_after_poll, clk, rst, done, $past(state == S_POLL), "result strobe without poll")
  `RTJS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted transaction not busy")
  `RTJS_ASSERT_IMPLIES(a_run_ends, clk, rst, state == S_IDLE, (run_head == NIL_SLOT) == (run_tail == NIL_SLOT), "run queue head and tail disagree")
  `RTJS_ASSERT_IMPLIES(a_timed_after_run, clk, rst, done && result.from_timed, $past(run_head == NIL_SLOT), "timed dispatch with run queue pending")

endmodule
